>>> src/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg
// Shared types and constants of the LED matrix PWM scanner.
// ----------------------------------------------------------------------------
package lmps_pkg;

    localparam int ROWS    = 8;
    localparam int COLUMNS = 8;
    localparam int LEVELS  = 4;

    localparam int LED_COUNT   = ROWS * COLUMNS;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEVEL_W     = 4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] led_num;
        logic [3:0] brightness;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] row_drive;
        logic [2:0] column_select;
        logic [3:0] pwm_slot;
    } res_item_t;

endpackage

>>> src/led_matrix_pwm_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner
// Multiplexed LED matrix driver with per-LED PWM brightness.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A write stores a brightness
// (saturated at LEVELS, ignored beyond the matrix). A tick steps the scan
// sequencer: a blanking tick does not scan, while a PWM or column tick walks
// the single read port of the brightness store one row per cycle through a
// shared level compare. The input is stalled while a transaction is in
// progress; a finished result may wait in the output register while the next
// command is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module led_matrix_pwm_scanner
    import lmps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_PWM    = 2'd0,
        PH_BLANK  = 2'd1,
        PH_COLUMN = 2'd2
    } phase_t;

    state_t              state_reg,     state_next;
    phase_t              phase_reg,     phase_next;
    logic [3:0]          slot_reg,      slot_next;
    logic [2:0]          col_reg,       col_next;
    logic [7:0]          rows_reg,      rows_next;
    logic [2:0]          row_cnt_reg,   row_cnt_next;
    logic [ADDR_W-1:0]   addr_reg,      addr_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [2:0]          cmp_row_reg,   cmp_row_next;
    logic                res_valid_reg, res_valid_next;
    res_item_t           res_reg,       res_next;

    logic                wr_en;
    logic [LEVEL_W-1:0]  wr_level;
    logic [LEVEL_W-1:0]  rd_level;
    logic [2:0]          col_inc;
    logic [3:0]          slot_inc;

    lmps_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (cmd.led_num[ADDR_W-1:0]),
        .wr_level (wr_level),
        .rd_addr  (addr_reg),
        .rd_level (rd_level)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign wr_level = (cmd.brightness > 4'(LEVELS)) ? 4'(LEVELS) : cmd.brightness;
    assign col_inc  = col_reg + 3'd1;
    assign slot_inc = slot_reg + 4'd1;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        slot_next      = slot_reg;
        col_next       = col_reg;
        rows_next      = rows_reg;
        row_cnt_next   = row_cnt_reg;
        addr_next      = addr_reg;
        cmp_valid_next = 1'b0;
        cmp_row_next   = cmp_row_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_WRITE)
                    begin
                        wr_en      = (cmd.led_num < 8'(LED_COUNT));
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_BLANK:
                            begin
                                slot_next  = '0;
                                rows_next  = '0;
                                phase_next = PH_COLUMN;
                                state_next = ST_FINISH;
                            end
                            PH_COLUMN:
                            begin
                                // wrap at the last column, also for a full 8
                                col_next   = ({1'b0, col_inc} >= 4'(COLUMNS)) ? 3'd0 : col_inc;
                                phase_next = PH_PWM;
                                state_next = ST_SCAN;
                            end
                            default:
                            begin
                                slot_next = slot_inc;
                                if (slot_inc >= 4'(LEVELS - 1))
                                begin
                                    phase_next = PH_BLANK;
                                end
                                state_next = ST_SCAN;
                            end
                        endcase
                        if (state_next == ST_SCAN)
                        begin
                            rows_next    = '0;
                            row_cnt_next = '0;
                            addr_next    = ADDR_W'(col_next);
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // read issued at addr_reg, compared in the next cycle
                cmp_valid_next = 1'b1;
                cmp_row_next   = row_cnt_reg;
                row_cnt_next   = row_cnt_reg + 3'd1;
                addr_next      = addr_reg + ADDR_W'(COLUMNS);
                if (row_cnt_reg == 3'(ROWS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next         = 1'b1;
                    res_next.row_drive     = rows_reg;
                    res_next.column_select = col_reg;
                    res_next.pwm_slot      = slot_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shared level compare against the current slot
        if (cmp_valid_reg && (rd_level > slot_reg))
        begin
            rows_next[cmp_row_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PWM;
            slot_reg      <= '0;
            col_reg       <= '0;
            rows_reg      <= '0;
            row_cnt_reg   <= '0;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_row_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            slot_reg      <= slot_next;
            col_reg       <= col_next;
            rows_reg      <= rows_next;
            row_cnt_reg   <= row_cnt_next;
            addr_reg      <= addr_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_row_reg   <= cmp_row_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

>>> src/lmps_store.sv
// ----------------------------------------------------------------------------
// lmps_store
// Brightness store: one write port, one registered read port. Each entry has
// a valid bit cleared at reset, so an unwritten entry reads as level zero.
// ----------------------------------------------------------------------------
module lmps_store
    import lmps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [LEVEL_W-1:0] wr_level,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [LEVEL_W-1:0] rd_level
);

    logic [LEVEL_W-1:0]     level_mem_reg [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [LEVEL_W-1:0]     rd_data_reg;
    logic                   rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            level_mem_reg[wr_addr] <= wr_level;
        end
        rd_data_reg <= level_mem_reg[rd_addr];
        rd_hit_reg  <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_level = rd_hit_reg ? rd_data_reg : '0;

endmodule
